// ===== design/ssl_pkg.sv =====
// Shared types, constants and helper functions for the source lexer.
package ssl_pkg;

    // Counter widths
    localparam int OFFSET_BITS = 32;
    localparam int LINE_BITS   = 24;
    localparam int COLUMN_BITS = 16;
    localparam int LENGTH_BITS = 16;

    // Records one item can produce, and queue sizing
    localparam int MAX_RECS       = 6;
    localparam int REC_CNT_BITS   = $clog2(MAX_RECS + 1);
    localparam int QUEUE_DEPTH    = 2;
    localparam int QUEUE_AW       = $clog2(QUEUE_DEPTH);
    localparam int CFG_REGS       = 4;
    localparam int CFG_INDEX_BITS = $clog2(CFG_REGS);
    localparam int CFG_DATA_BITS  = 64;
    localparam int SYM_SET_BITS   = CFG_REGS * CFG_DATA_BITS;

    // Character codes
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_USCORE = 8'h5F;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_LOW_A  = 8'h61;
    localparam logic [7:0] CH_LOW_Z  = 8'h7A;
    localparam logic [7:0] CH_UP_A   = 8'h41;
    localparam logic [7:0] CH_UP_Z   = 8'h5A;
    localparam logic [7:0] CH_DIG_0  = 8'h30;
    localparam logic [7:0] CH_DIG_9  = 8'h39;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;

    typedef enum logic [2:0] {
        M_IDLE, M_SLASH, M_COMMENT, M_IDENT, M_NUMBER, M_STRING, M_ESC
    } mode_t;

    typedef enum logic [2:0] {
        K_TEXT, K_IDENT, K_NUMBER, K_STRING, K_SYMBOL, K_END, K_ERROR
    } kind_t;

    typedef enum logic [1:0] {
        E_NONE, E_UNTERM, E_UNEXPECTED
    } err_t;

    // Which of the three positions stored with a queue entry a record uses
    typedef enum logic [1:0] {
        P_START, P_CUR, P_FIN
    } psel_t;

    typedef struct packed {
        logic [OFFSET_BITS-1:0] offset;
        logic [LINE_BITS-1:0]   line;
        logic [COLUMN_BITS-1:0] column;
    } pos_t;

    localparam pos_t POS_RESET = '{
        offset: '0,
        line:   LINE_BITS'(1),
        column: COLUMN_BITS'(1)
    };

    typedef struct packed {
        kind_t                  kind;
        err_t                   err;
        logic [7:0]             tbyte;
        psel_t                  psel;
        logic [LENGTH_BITS-1:0] len;
    } rec_t;

    // One queue entry: every record of one input item
    typedef struct packed {
        logic [REC_CNT_BITS-1:0] rec_cnt;
        pos_t                    start0;
        pos_t                    cur;
        pos_t                    fin;
        rec_t [MAX_RECS-1:0]     recs;
    } entry_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       has_byte;
        logic       end_of_input;
    } in_item_t;

    typedef struct packed {
        logic [2:0]             record_kind;
        logic [1:0]             error_code;
        logic [7:0]             text_byte;
        logic [OFFSET_BITS-1:0] token_offset;
        logic [LINE_BITS-1:0]   token_line;
        logic [COLUMN_BITS-1:0] token_column;
        logic [LENGTH_BITS-1:0] token_length;
        logic                   last_of_run;
    } out_item_t;

    function automatic logic is_alpha(input logic [7:0] c);
        return ((c >= CH_LOW_A) && (c <= CH_LOW_Z)) || ((c >= CH_UP_A) && (c <= CH_UP_Z));
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CH_DIG_0) && (c <= CH_DIG_9);
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
    endfunction

    function automatic logic [OFFSET_BITS-1:0] sat_off(input logic [OFFSET_BITS-1:0] v);
        return (v == '1) ? v : v + 1'b1;
    endfunction

    function automatic logic [LINE_BITS-1:0] sat_line(input logic [LINE_BITS-1:0] v);
        return (v == '1) ? v : v + 1'b1;
    endfunction

    function automatic logic [COLUMN_BITS-1:0] sat_col(input logic [COLUMN_BITS-1:0] v);
        return (v == '1) ? v : v + 1'b1;
    endfunction

    function automatic logic [LENGTH_BITS-1:0] sat_len(input logic [LENGTH_BITS-1:0] v);
        return (v == '1) ? v : v + 1'b1;
    endfunction

    function automatic rec_t mk_rec(input kind_t kind, input err_t err,
                                    input logic [7:0] tbyte, input psel_t psel,
                                    input logic [LENGTH_BITS-1:0] len);
        rec_t r;
        r.kind  = kind;
        r.err   = err;
        r.tbyte = tbyte;
        r.psel  = psel;
        r.len   = len;
        return r;
    endfunction

endpackage

// ===== design/ssl_front.sv =====
// Front end: accepts source bytes, runs the lexer state and lists each item's records.
module ssl_front (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  ssl_pkg::in_item_t                  s_data,
    input  logic                               cfg_valid,
    input  logic [ssl_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [ssl_pkg::CFG_DATA_BITS-1:0]  cfg_data,
    input  ssl_pkg::q_status_t                 q_stat,
    output logic                               push,
    output ssl_pkg::entry_t                    push_entry
);
    import ssl_pkg::*;

    logic [CFG_DATA_BITS-1:0] sym_reg [CFG_REGS];
    logic [SYM_SET_BITS-1:0]  sym_set;

    mode_t                   mode_reg, mode_next;
    logic                    dot_reg, dot_next;
    pos_t                    pos_reg, pos_next;
    pos_t                    start_reg, start_next;
    logic [LENGTH_BITS-1:0]  count_reg, count_next;

    logic                    accept;
    logic [7:0]              c;
    logic                    escaped;
    logic                    do_idle;
    psel_t                   sel_v;
    logic [REC_CNT_BITS-1:0] n_v;
    rec_t [MAX_RECS-1:0]     recs_v;
    pos_t                    fin_v;

    assign sym_set = {sym_reg[3], sym_reg[2], sym_reg[1], sym_reg[0]};
    assign s_ready = !q_stat.full;
    assign accept  = s_valid && s_ready;

    // Lexer step: state update and the record list for this beat
    always_comb begin
        c          = s_data.data_byte;
        escaped    = (mode_reg == M_ESC);
        mode_next  = mode_reg;
        dot_next   = dot_reg;
        pos_next   = pos_reg;
        start_next = start_reg;
        count_next = count_reg;
        sel_v      = P_START;
        do_idle    = 1'b0;
        n_v        = '0;
        recs_v     = '0;
        fin_v      = pos_reg;

        if (s_data.has_byte) begin
            // close or extend the open token
            case (mode_reg)
                M_SLASH: begin
                    if (c == CH_SLASH) begin
                        mode_next = M_COMMENT;
                    end else begin
                        if (sym_set[CH_SLASH]) begin
                            count_next = sat_len('0);
                            recs_v[n_v] = mk_rec(K_TEXT, E_NONE, CH_SLASH, sel_v, count_next);
                            n_v = n_v + 1'b1;
                            recs_v[n_v] = mk_rec(K_SYMBOL, E_NONE, '0, sel_v, count_next);
                            n_v = n_v + 1'b1;
                        end else begin
                            recs_v[n_v] = mk_rec(K_ERROR, E_UNEXPECTED, '0, sel_v, '0);
                            n_v = n_v + 1'b1;
                        end
                        do_idle = 1'b1;
                    end
                end
                M_COMMENT: begin
                    if (c == CH_LF) begin
                        do_idle = 1'b1;
                    end
                end
                M_IDENT: begin
                    if (is_alpha(c) || is_digit(c) || (c == CH_USCORE)) begin
                        count_next = sat_len(count_next);
                        recs_v[n_v] = mk_rec(K_TEXT, E_NONE, c, sel_v, count_next);
                        n_v = n_v + 1'b1;
                    end else begin
                        recs_v[n_v] = mk_rec(K_IDENT, E_NONE, '0, sel_v, count_next);
                        n_v = n_v + 1'b1;
                        do_idle = 1'b1;
                    end
                end
                M_NUMBER: begin
                    if (is_digit(c) || ((c == CH_DOT) && !dot_reg)) begin
                        if (c == CH_DOT) begin
                            dot_next = 1'b1;
                        end
                        count_next = sat_len(count_next);
                        recs_v[n_v] = mk_rec(K_TEXT, E_NONE, c, sel_v, count_next);
                        n_v = n_v + 1'b1;
                    end else begin
                        recs_v[n_v] = mk_rec(K_NUMBER, E_NONE, '0, sel_v, count_next);
                        n_v = n_v + 1'b1;
                        do_idle = 1'b1;
                    end
                end
                M_STRING: begin
                    if (c == CH_LF) begin
                        recs_v[n_v] = mk_rec(K_ERROR, E_UNTERM, '0, sel_v, '0);
                        n_v = n_v + 1'b1;
                        do_idle = 1'b1;
                    end else if (c == CH_QUOTE) begin
                        recs_v[n_v] = mk_rec(K_STRING, E_NONE, '0, sel_v, count_next);
                        n_v = n_v + 1'b1;
                        mode_next = M_IDLE;
                    end else if (c == CH_BSLASH) begin
                        mode_next = M_ESC;
                    end else begin
                        count_next = sat_len(count_next);
                        recs_v[n_v] = mk_rec(K_TEXT, E_NONE, c, sel_v, count_next);
                        n_v = n_v + 1'b1;
                    end
                end
                M_ESC: begin
                    count_next = sat_len(count_next);
                    recs_v[n_v] = mk_rec(K_TEXT, E_NONE, c, sel_v, count_next);
                    n_v = n_v + 1'b1;
                    mode_next = M_STRING;
                end
                default: begin
                    do_idle = 1'b1;
                end
            endcase

            // start a new token from this byte
            if (do_idle) begin
                mode_next = M_IDLE;
                if (!is_space(c)) begin
                    if (c == CH_SLASH || is_alpha(c) || c == CH_USCORE || is_digit(c)
                        || c == CH_QUOTE || sym_set[c]) begin
                        sel_v      = P_CUR;
                        count_next = '0;
                        start_next = pos_reg;
                    end
                    if (c == CH_SLASH) begin
                        mode_next = M_SLASH;
                    end else if (is_alpha(c) || (c == CH_USCORE)) begin
                        mode_next = M_IDENT;
                        count_next = sat_len(count_next);
                        recs_v[n_v] = mk_rec(K_TEXT, E_NONE, c, sel_v, count_next);
                        n_v = n_v + 1'b1;
                    end else if (is_digit(c)) begin
                        mode_next = M_NUMBER;
                        dot_next  = 1'b0;
                        count_next = sat_len(count_next);
                        recs_v[n_v] = mk_rec(K_TEXT, E_NONE, c, sel_v, count_next);
                        n_v = n_v + 1'b1;
                    end else if (c == CH_QUOTE) begin
                        mode_next = M_STRING;
                    end else if (sym_set[c]) begin
                        count_next = sat_len(count_next);
                        recs_v[n_v] = mk_rec(K_TEXT, E_NONE, c, sel_v, count_next);
                        n_v = n_v + 1'b1;
                        recs_v[n_v] = mk_rec(K_SYMBOL, E_NONE, '0, sel_v, count_next);
                        n_v = n_v + 1'b1;
                    end else begin
                        recs_v[n_v] = mk_rec(K_ERROR, E_UNEXPECTED, '0, P_CUR, '0);
                        n_v = n_v + 1'b1;
                    end
                end
            end

            // advance position; an escaped newline only moves the column
            pos_next.offset = sat_off(pos_reg.offset);
            if ((c == CH_LF) && !escaped) begin
                pos_next.line   = sat_line(pos_reg.line);
                pos_next.column = COLUMN_BITS'(1);
            end else begin
                pos_next.column = sat_col(pos_reg.column);
            end
            fin_v = pos_next;
        end

        // end of text: flush the open token, then the end record
        if (s_data.end_of_input) begin
            case (mode_next)
                M_SLASH: begin
                    if (sym_set[CH_SLASH]) begin
                        count_next = sat_len('0);
                        recs_v[n_v] = mk_rec(K_TEXT, E_NONE, CH_SLASH, sel_v, count_next);
                        n_v = n_v + 1'b1;
                        recs_v[n_v] = mk_rec(K_SYMBOL, E_NONE, '0, sel_v, count_next);
                        n_v = n_v + 1'b1;
                    end else begin
                        recs_v[n_v] = mk_rec(K_ERROR, E_UNEXPECTED, '0, sel_v, '0);
                        n_v = n_v + 1'b1;
                    end
                end
                M_IDENT: begin
                    recs_v[n_v] = mk_rec(K_IDENT, E_NONE, '0, sel_v, count_next);
                    n_v = n_v + 1'b1;
                end
                M_NUMBER: begin
                    recs_v[n_v] = mk_rec(K_NUMBER, E_NONE, '0, sel_v, count_next);
                    n_v = n_v + 1'b1;
                end
                M_STRING: begin
                    recs_v[n_v] = mk_rec(K_ERROR, E_UNTERM, '0, sel_v, '0);
                    n_v = n_v + 1'b1;
                end
                M_ESC: begin
                    count_next = sat_len(count_next);
                    recs_v[n_v] = mk_rec(K_TEXT, E_NONE, CH_BSLASH, sel_v, count_next);
                    n_v = n_v + 1'b1;
                    recs_v[n_v] = mk_rec(K_ERROR, E_UNTERM, '0, sel_v, '0);
                    n_v = n_v + 1'b1;
                end
                default: begin
                end
            endcase
            recs_v[n_v] = mk_rec(K_END, E_NONE, '0, P_FIN, '0);
            n_v = n_v + 1'b1;

            mode_next  = M_IDLE;
            dot_next   = 1'b0;
            pos_next   = POS_RESET;
            start_next = POS_RESET;
            count_next = '0;
        end
    end

    assign push               = accept && (n_v != '0);
    assign push_entry.rec_cnt = n_v;
    assign push_entry.start0  = start_reg;
    assign push_entry.cur     = pos_reg;
    assign push_entry.fin     = fin_v;
    assign push_entry.recs    = recs_v;

    // Lexer state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= M_IDLE;
            dot_reg   <= 1'b0;
            pos_reg   <= POS_RESET;
            start_reg <= POS_RESET;
            count_reg <= '0;
        end else if (accept) begin
            mode_reg  <= mode_next;
            dot_reg   <= dot_next;
            pos_reg   <= pos_next;
            start_reg <= start_next;
            count_reg <= count_next;
        end
    end

    // Symbol set registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < CFG_REGS; i++) begin
                sym_reg[i] <= '0;
            end
        end else if (cfg_valid) begin
            sym_reg[cfg_index] <= cfg_data;
        end
    end

endmodule

// ===== design/ssl_queue.sv =====
// Short queue of per-beat record lists between front and back.
module ssl_queue (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               push,
    input  ssl_pkg::entry_t    push_entry,
    input  logic               pop,
    output ssl_pkg::entry_t    head,
    output ssl_pkg::q_status_t q_stat
);
    import ssl_pkg::*;

    entry_t              mem_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QUEUE_AW:0]   cnt_reg, cnt_next;
    logic                do_push, do_pop;

    assign q_stat.full  = (cnt_reg == (QUEUE_AW + 1)'(QUEUE_DEPTH));
    assign q_stat.empty = (cnt_reg == '0);
    assign do_push      = push && !q_stat.full;
    assign do_pop       = pop && !q_stat.empty;
    assign head         = mem_reg[rd_ptr_reg];

    // Occupancy
    always_comb begin
        cnt_next = cnt_reg;
        if (do_push && !do_pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            cnt_reg <= cnt_next;
        end
    end

    // Entry storage
    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

// ===== design/ssl_back.sv =====
// Back end: walks each queued record list and drives one result beat per cycle while m_ready is high.
module ssl_back (
    input  logic               aclk,
    input  logic               aresetn,
    input  ssl_pkg::entry_t    head,
    input  ssl_pkg::q_status_t q_stat,
    output logic               pop,
    output logic               m_valid,
    input  logic               m_ready,
    output ssl_pkg::out_item_t m_data
);
    import ssl_pkg::*;

    logic [REC_CNT_BITS-1:0] idx_reg, idx_next;
    logic                    out_valid_reg, out_valid_next;
    out_item_t               out_reg, out_next;
    rec_t                    rec;
    pos_t                    pos;
    logic                    is_last;
    logic                    load;

    // Record selection and output register load
    always_comb begin
        rec     = head.recs[idx_reg];
        is_last = (idx_reg == (head.rec_cnt - 1'b1));
        load    = !q_stat.empty && (!out_valid_reg || m_ready);
        pop     = load && is_last;

        case (rec.psel)
            P_START: pos = head.start0;
            P_CUR:   pos = head.cur;
            P_FIN:   pos = head.fin;
            default: pos = head.fin;
        endcase

        out_next.record_kind  = rec.kind;
        out_next.error_code   = rec.err;
        out_next.text_byte    = rec.tbyte;
        out_next.token_offset = pos.offset;
        out_next.token_line   = pos.line;
        out_next.token_column = pos.column;
        out_next.token_length = rec.len;
        out_next.last_of_run  = is_last;

        idx_next       = idx_reg;
        out_valid_next = out_valid_reg && !m_ready;
        if (load) begin
            idx_next       = is_last ? '0 : idx_reg + 1'b1;
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            out_reg <= out_next;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

endmodule

// ===== design/strict_source_lexer.sv =====
// Streaming source lexer: one source byte per input beat, token records out.
// An accepted beat is queued first; its results then pass through the output register.
// Throughput: an input beat can be taken every cycle while the two-entry queue has room;
// the back end sends one result per cycle while m_ready is high and pops a beat after its last result.
// Reset: synchronous, active low; lexer state, queue and output clear, symbol set reads zero.
// Configuration is always ready; a write lands in the symbol set on its handshake.
module strict_source_lexer (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  ssl_pkg::in_item_t                  s_data,
    output logic                               m_valid,
    input  logic                               m_ready,
    output ssl_pkg::out_item_t                 m_data,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [ssl_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [ssl_pkg::CFG_DATA_BITS-1:0]  cfg_data
);
    import ssl_pkg::*;

    logic      push;
    logic      pop;
    entry_t    push_entry;
    entry_t    head;
    q_status_t q_stat;

    assign cfg_ready = 1'b1;

    ssl_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .cfg_valid  (cfg_valid),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .q_stat     (q_stat),
        .push       (push),
        .push_entry (push_entry)
    );

    ssl_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .q_stat     (q_stat)
    );

    ssl_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .head    (head),
        .q_stat  (q_stat),
        .pop     (pop),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

// ===== design/ssl_checker.sv =====
// Port-level checks on the lexer's result channel, bound to the top level.
module ssl_checker (
    input logic               aclk,
    input logic               aresetn,
    input logic               m_valid,
    input logic               m_ready,
    input ssl_pkg::out_item_t m_data
);
    import ssl_pkg::*;

    // A stalled result beat holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result beat changed while stalled");

    // Error code present exactly on error records
    a_err_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ((m_data.record_kind == K_ERROR) == (m_data.error_code != E_NONE)))
        else $error("error code does not match record kind");

    // Text byte only on text records
    a_text_byte: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.record_kind != K_TEXT) |-> (m_data.text_byte == '0))
        else $error("text byte set on a non-text record");

    // End record closes its beat's run and carries no length
    a_end_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.record_kind == K_END)
            |-> m_data.last_of_run && (m_data.token_length == '0))
        else $error("end record not last or has a length");

    // Line and column are one-based
    a_pos_base: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.token_line != '0) && (m_data.token_column != '0))
        else $error("zero line or column");

endmodule

bind strict_source_lexer ssl_checker u_ssl_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
